>>> sv/sip_pkg.sv
package sip_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordicMax      = 32;
  localparam int RootSteps      = 34;
  localparam int RootLat        = RootSteps + 1;
  localparam int QuotBits       = 34;
  localparam int DivLat         = QuotBits + 1;
  localparam int NumW           = 67;
  localparam int ProdW          = NumW + QuotBits;
  localparam int LenW           = 34;
  localparam int RemW           = 38;
  localparam int RadW           = 68;
  localparam logic [32:0] DistMax = '1;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic signed [15:0] heading;
    logic        [32:0] along_distance;
  } out_item_t;

  typedef struct packed {
    logic               hit;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic signed [32:0] dax;
    logic signed [32:0] day;
    logic        [32:0] dax_mag;
    logic        [32:0] day_mag;
    logic   [NumW-1:0]  num;
    logic   [NumW-1:0]  den;
    logic   [RadW-3:0]  len2;
  } front_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        dax_neg;
    logic        day_neg;
    logic [15:0] heading;
  } side_t;

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic opposite(input logic signed [67:0] a, input logic signed [67:0] b);
    return (a != '0) && (b != '0) && (a[67] != b[67]);
  endfunction

  function automatic logic [31:0] atan_at(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/sip_front.sv
module sip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sip_pkg::in_item_t item_i,
  output logic              valid_o,
  output sip_pkg::front_t   data_o
);
  import sip_pkg::*;

  logic [2:0] valid_q;

  logic        [31:0] ax0_q, ay0_q;
  logic signed [32:0] dax0_q, day0_q, wx_q, wy_q, dbx_q, dby_q;

  logic        [31:0] ax1_q, ay1_q;
  logic signed [32:0] dax1_q, day1_q;
  logic signed [65:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic        [64:0] sqx_q, sqy_q;

  logic signed [65:0] p0_d, p1_d, p2_d, p3_d, p4_d, p5_d, sqx_d, sqy_d;
  logic signed [67:0] den_s, den_n, num_s, num_n, s1_s, s2_s, nmd_s;
  front_t             data_d, data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_comb begin
    p0_d  = dax0_q * dby_q;
    p1_d  = day0_q * dbx_q;
    p2_d  = wx_q * dby_q;
    p3_d  = wy_q * dbx_q;
    p4_d  = dax0_q * wy_q;
    p5_d  = day0_q * wx_q;
    sqx_d = dax0_q * dax0_q;
    sqy_d = day0_q * day0_q;
  end

  always_comb begin
    den_s = 68'(p0_q) - 68'(p1_q);
    den_n = 68'(p1_q) - 68'(p0_q);
    num_s = 68'(p2_q) - 68'(p3_q);
    num_n = 68'(p3_q) - 68'(p2_q);
    s1_s  = 68'(p4_q) - 68'(p5_q);
    s2_s  = s1_s + den_s;
    nmd_s = num_s - den_s;
    data_d.hit     = opposite(s1_s, s2_s) && opposite(num_s, nmd_s);
    data_d.ax      = ax1_q;
    data_d.ay      = ay1_q;
    data_d.dax     = dax1_q;
    data_d.day     = day1_q;
    data_d.dax_mag = dax1_q[32] ? 33'(-dax1_q) : 33'(dax1_q);
    data_d.day_mag = day1_q[32] ? 33'(-day1_q) : 33'(day1_q);
    data_d.den     = den_s[67] ? den_n[NumW-1:0] : den_s[NumW-1:0];
    data_d.num     = den_s[67] ? num_n[NumW-1:0] : num_s[NumW-1:0];
    data_d.len2    = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax0_q  <= item_i.a_start_x;
      ay0_q  <= item_i.a_start_y;
      dax0_q <= sx33(item_i.a_end_x) - sx33(item_i.a_start_x);
      day0_q <= sx33(item_i.a_end_y) - sx33(item_i.a_start_y);
      wx_q   <= sx33(item_i.b_start_x) - sx33(item_i.a_start_x);
      wy_q   <= sx33(item_i.b_start_y) - sx33(item_i.a_start_y);
      dbx_q  <= sx33(item_i.b_end_x) - sx33(item_i.b_start_x);
      dby_q  <= sx33(item_i.b_end_y) - sx33(item_i.b_start_y);
      ax1_q  <= ax0_q;
      ay1_q  <= ay0_q;
      dax1_q <= dax0_q;
      day1_q <= day0_q;
      p0_q   <= p0_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      p3_q   <= p3_d;
      p4_q   <= p4_d;
      p5_q   <= p5_d;
      sqx_q  <= sqx_d[64:0];
      sqy_q  <= sqy_d[64:0];
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = data_q;

endmodule

>>> sv/sip_root.sv
module sip_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sip_pkg::front_t               data_i,
  output logic                          valid_o,
  output sip_pkg::front_t               data_o,
  output logic [sip_pkg::LenW-1:0]      len_o
);
  import sip_pkg::*;

  logic [RemW-1:0] rem_q  [RootSteps];
  logic [LenW-1:0] root_q [RootSteps];
  logic [RadW-1:0] rad_q  [RootSteps];
  front_t          car_q  [RootSteps];
  logic            v_q    [RootSteps];

  logic [LenW-1:0] len_q;
  front_t          car_fin_q;
  logic            v_fin_q;

  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    logic [RemW-1:0] rem_in, rs, trial, rem_d;
    logic [LenW-1:0] root_in, root_d;
    logic [RadW-1:0] rad_in;
    front_t          car_in;
    logic            v_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {2'b00, data_i.len2};
      assign car_in  = data_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign car_in  = car_q[k-1];
      assign v_in    = v_q[k-1];
    end

    always_comb begin
      rs    = {rem_in[RemW-3:0], rad_in[RadW-1:RadW-2]};
      trial = RemW'({root_in, 2'b01});
      if (rs >= trial) begin
        rem_d  = rs - trial;
        root_d = {root_in[LenW-2:0], 1'b1};
      end else begin
        rem_d  = rs;
        root_d = {root_in[LenW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
        car_q[k]  <= car_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_fin_q <= 1'b0;
    end else if (en_i) begin
      v_fin_q <= v_q[RootSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_fin_q <= car_q[RootSteps-1];
      if (rem_q[RootSteps-1] > RemW'(root_q[RootSteps-1])) begin
        len_q <= root_q[RootSteps-1] + LenW'(1);
      end else begin
        len_q <= root_q[RootSteps-1];
      end
    end
  end

  assign valid_o = v_fin_q;
  assign data_o  = car_fin_q;
  assign len_o   = len_q;

endmodule

>>> sv/sip_cordic.sv
module sip_cordic #(
  parameter int Steps = sip_pkg::CordicStepsDef,
  parameter int Lat   = sip_pkg::RootLat
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  output logic        [15:0] heading_o
);
  import sip_pkg::*;

  localparam int NSteps = (Steps > CordicMax) ? CordicMax : Steps;

  logic signed [35:0] x_q [Lat];
  logic signed [35:0] y_q [Lat];
  logic signed [33:0] z_q [Lat];

  logic signed [35:0] x0, y0;
  logic signed [33:0] zr;

  always_comb begin
    x0 = 36'(dx_i);
    y0 = 36'(dy_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_q[0] <= y0;
          y_q[0] <= -x0;
          z_q[0] <= 34'sd1073741824;
        end else begin
          x_q[0] <= -y0;
          y_q[0] <= x0;
          z_q[0] <= -34'sd1073741824;
        end
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k < Lat; k++) begin : g_stage
    if (k - 1 < NSteps) begin : g_rot
      logic signed [35:0] xs, ys;
      logic signed [33:0] at;
      always_comb begin
        xs = x_q[k-1] >>> (k - 1);
        ys = y_q[k-1] >>> (k - 1);
        at = $signed({2'b00, atan_at(k - 1)});
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (y_q[k-1] > 0) begin
            x_q[k] <= x_q[k-1] + ys;
            y_q[k] <= y_q[k-1] - xs;
            z_q[k] <= z_q[k-1] + at;
          end else begin
            x_q[k] <= x_q[k-1] - ys;
            y_q[k] <= y_q[k-1] + xs;
            z_q[k] <= z_q[k-1] - at;
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k] <= x_q[k-1];
          y_q[k] <= y_q[k-1];
          z_q[k] <= z_q[k-1];
        end
      end
    end
  end

  assign zr        = z_q[Lat-1] + 34'sd32768;
  assign heading_o = zr[31:16];

endmodule

>>> sv/sip_div.sv
module sip_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [sip_pkg::ProdW-1:0]    n_i,
  input  logic [sip_pkg::NumW-1:0]     d_i,
  output logic [sip_pkg::QuotBits:0]   q_o
);
  import sip_pkg::*;

  logic [NumW-1:0]     r_q  [QuotBits];
  logic [QuotBits-1:0] lo_q [QuotBits];
  logic [QuotBits-1:0] q_q  [QuotBits];
  logic [NumW-1:0]     d_q  [QuotBits];
  logic [QuotBits:0]   res_q;

  for (genvar k = 0; k < QuotBits; k++) begin : g_step
    logic [NumW-1:0]     r_in, d_in, r_d;
    logic [QuotBits-1:0] lo_in, q_in, q_d;
    logic [NumW:0]       r2, dd;

    if (k == 0) begin : g_first
      assign r_in  = n_i[ProdW-1:QuotBits];
      assign lo_in = n_i[QuotBits-1:0];
      assign q_in  = '0;
      assign d_in  = d_i;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign lo_in = lo_q[k-1];
      assign q_in  = q_q[k-1];
      assign d_in  = d_q[k-1];
    end

    always_comb begin
      r2 = {r_in, lo_in[QuotBits-1]};
      dd = {1'b0, d_in};
      if (r2 >= dd) begin
        r_d = NumW'(r2 - dd);
        q_d = {q_in[QuotBits-2:0], 1'b1};
      end else begin
        r_d = r2[NumW-1:0];
        q_d = {q_in[QuotBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= r_d;
        lo_q[k] <= {lo_in[QuotBits-2:0], 1'b0};
        q_q[k]  <= q_d;
        d_q[k]  <= d_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if ({r_q[QuotBits-1], 1'b0} >= {1'b0, d_q[QuotBits-1]}) begin
        res_q <= {1'b0, q_q[QuotBits-1]} + (QuotBits+1)'(1);
      end else begin
        res_q <= {1'b0, q_q[QuotBits-1]};
      end
    end
  end

  assign q_o = res_q;

endmodule

>>> sv/segment_intersection_point.sv
// Channel  | Direction | Handshake                  | Payload
// in       | input     | in_valid_i / in_stall_o    | in_item_i  (sip_pkg::in_item_t)
// out      | output    | out_valid_o / out_stall_i  | out_item_o (sip_pkg::out_item_t)
//
// One item enters per cycle while in_stall_o is low; each result passes through
// 3 front stages, 35 square root stages, 2 multiply stages, 35 divider stages and
// 1 output queue stage; the square root and divider bit stages set the depth.
// Reset clears all valid bits and empties the two-entry output queue.
// The pipeline advances as a whole while the output queue has room; in_stall_o
// rises only when both queue entries hold results that wait.
module segment_intersection_point #(
  parameter int CORDIC_STEPS = sip_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sip_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sip_pkg::out_item_t out_item_o
);
  import sip_pkg::*;

  logic            en;
  logic            fr_valid, rt_valid;
  front_t          fr_data, rt_data;
  logic [LenW-1:0] rt_len;
  logic [15:0]     heading;

  logic            m1_valid_q, m2_valid_q;
  side_t           m1_side_q, m2_side_q;
  logic [67:0]     px_lo_q, py_lo_q, pl_lo_q;
  logic [66:0]     px_hi_q, py_hi_q, pl_hi_q;
  logic [NumW-1:0] den1_q, den2_q;
  logic [ProdW-1:0] nx_q, ny_q, nl_q;

  logic [QuotBits:0] qx, qy, ql;
  side_t           side_dl_q  [DivLat];
  logic            valid_dl_q [DivLat];

  side_t           side_l;
  out_item_t       fin;
  logic [34:0]     cx_sum, cy_sum;

  out_item_t       queue_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      count_q, count_d;
  logic            push, pop;

  assign en         = (count_q != 2'd2);
  assign in_stall_o = !en;

  sip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  sip_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (rt_valid),
    .data_o  (rt_data),
    .len_o   (rt_len)
  );

  sip_cordic #(
    .Steps (CORDIC_STEPS),
    .Lat   (RootLat)
  ) u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .dx_i      (fr_data.dax),
    .dy_i      (fr_data.day),
    .heading_o (heading)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= rt_valid;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q.hit     <= rt_data.hit;
      m1_side_q.ax      <= rt_data.ax;
      m1_side_q.ay      <= rt_data.ay;
      m1_side_q.dax_neg <= rt_data.dax[32];
      m1_side_q.day_neg <= rt_data.day[32];
      m1_side_q.heading <= heading;
      px_lo_q <= rt_data.num[33:0] * {1'b0, rt_data.dax_mag};
      px_hi_q <= rt_data.num[NumW-1:34] * {1'b0, rt_data.dax_mag};
      py_lo_q <= rt_data.num[33:0] * {1'b0, rt_data.day_mag};
      py_hi_q <= rt_data.num[NumW-1:34] * {1'b0, rt_data.day_mag};
      pl_lo_q <= rt_data.num[33:0] * rt_len;
      pl_hi_q <= rt_data.num[NumW-1:34] * rt_len;
      den1_q  <= rt_data.den;
      m2_side_q <= m1_side_q;
      nx_q    <= {px_hi_q, 34'b0} + ProdW'(px_lo_q);
      ny_q    <= {py_hi_q, 34'b0} + ProdW'(py_lo_q);
      nl_q    <= {pl_hi_q, 34'b0} + ProdW'(pl_lo_q);
      den2_q  <= den1_q;
    end
  end

  sip_div u_div_x (.clk_i(clk_i), .en_i(en), .n_i(nx_q), .d_i(den2_q), .q_o(qx));
  sip_div u_div_y (.clk_i(clk_i), .en_i(en), .n_i(ny_q), .d_i(den2_q), .q_o(qy));
  sip_div u_div_l (.clk_i(clk_i), .en_i(en), .n_i(nl_q), .d_i(den2_q), .q_o(ql));

  for (genvar k = 0; k < DivLat; k++) begin : g_dl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_dl_q[k] <= 1'b0;
      end else if (en) begin
        valid_dl_q[k] <= (k == 0) ? m2_valid_q : valid_dl_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_dl_q[k] <= (k == 0) ? m2_side_q : side_dl_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign side_l = side_dl_q[DivLat-1];

  always_comb begin
    cx_sum = {{3{side_l.ax[31]}}, side_l.ax} + (side_l.dax_neg ? (35'd0 - qx) : qx);
    cy_sum = {{3{side_l.ay[31]}}, side_l.ay} + (side_l.day_neg ? (35'd0 - qy) : qy);
    fin = '0;
    if (side_l.hit) begin
      fin.hit            = 1'b1;
      fin.cross_x        = cx_sum[31:0];
      fin.cross_y        = cy_sum[31:0];
      fin.heading        = side_l.heading;
      fin.along_distance = (ql[34:33] != 2'b00) ? DistMax : ql[32:0];
    end
  end

  assign push = en && valid_dl_q[DivLat-1];
  assign pop  = (count_q != 2'd0) && !out_stall_i;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= fin;
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = queue_q[rd_q];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue count out of range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.hit) |-> (out_item_o.cross_x == 0 &&
      out_item_o.cross_y == 0 && out_item_o.heading == 0 &&
      out_item_o.along_distance == 0))
    else $error("miss result carries nonzero fields");
`endif

endmodule
